// ----- design/polygon_orientation_and_bbox_defines.svh -----
// Assertion macros for the polyline orientation and bounding box block.
`ifndef POLYGON_ORIENTATION_AND_BBOX_DEFINES_SVH
`define POLYGON_ORIENTATION_AND_BBOX_DEFINES_SVH

`ifndef SYNTHESIS

`define POB_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("pob assertion failed");

`define POB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pob assertion failed");

`else

`define POB_ASSERT_ALWAYS(lbl, clk, rst, cond)

`define POB_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- design/pob_pkg.sv -----
// Shared constants and stage control types for the polyline orientation block.
package pob_pkg;

   localparam int POB_FIELD_BITS = 32;
   localparam int POB_ID_BITS    = 32;
   localparam int POB_COORD_BITS = 32;
   localparam int POB_ACC_BITS   = 64;

   // per-vertex position within its polyline
   typedef struct packed {
      logic first;
      logic last;
   } pob_tag_type;

   // pipeline advance controls, computed once in the top level
   typedef struct packed {
      logic s1_take;
      logic s1_go;
      logic s2_take;
      logic s2_go;
   } pob_adv_type;

endpackage

// ----- design/polygon_orientation_and_bbox.sv -----
// Top level of the polyline orientation and bounding box block.
//
//   channel  dir  handshake           beat
//   req_     in   req_valid/req_stall  one vertex: id, lon, lat, last flag
//   rsp_     out  rsp_valid/rsp_stall  one polyline: closed, clockwise, box
//
// One vertex beat per cycle is taken while req_stall is low; the last vertex passes the input
// register and product register, and then the result register raises rsp_valid.
// The two signed coordinate products sit one register stage ahead of the wrapping
// shoelace accumulator; vertices that are not last leave no beat.
// Synchronous reset clears the stage valids, the first-vertex flag and the accumulator.
// rsp_stall only holds back a last vertex; bubbles and other vertices keep moving, so
// req_stall rises only once the pipe behind a held result is full.
module polygon_orientation_and_bbox
   import pob_pkg::*;
#(
   parameter int COORD_BITS = POB_COORD_BITS,
   parameter int ACC_BITS   = POB_ACC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [POB_ID_BITS-1:0]    req_vertex_id,
   input  logic signed [POB_FIELD_BITS-1:0] req_lon,
   input  logic signed [POB_FIELD_BITS-1:0] req_lat,
   input  logic                             req_last_vertex,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_closed,
   output logic                             rsp_clockwise,
   output logic signed [POB_FIELD_BITS-1:0] rsp_min_lon,
   output logic signed [POB_FIELD_BITS-1:0] rsp_min_lat,
   output logic signed [POB_FIELD_BITS-1:0] rsp_max_lon,
   output logic signed [POB_FIELD_BITS-1:0] rsp_max_lat
);

   pob_adv_type                    adv;
   logic                           out_free;
   logic                           s1_valid, s2_valid, s2_closed;
   pob_tag_type                    s1_tag, s2_tag;
   logic [POB_ID_BITS-1:0]         s1_id;
   logic signed [COORD_BITS-1:0]   s1_x, s1_y, s1_px, s1_py;
   logic signed [2*COORD_BITS-1:0] s2_p1, s2_p2;
   logic signed [COORD_BITS-1:0]   box_min_lon, box_min_lat, box_max_lon, box_max_lat;

   // a stage takes a new beat when empty or when its current beat moves on
   always_comb begin
      adv.s2_go   = s2_valid && (!s2_tag.last || out_free);
      adv.s2_take = !s2_valid || adv.s2_go;
      adv.s1_go   = s1_valid && adv.s2_take;
      adv.s1_take = !s1_valid || adv.s1_go;
   end

   assign req_stall = !adv.s1_take;

   pob_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_vertex_id   (req_vertex_id),
      .req_lon         (req_lon),
      .req_lat         (req_lat),
      .req_last_vertex (req_last_vertex),
      .adv             (adv),
      .s1_valid        (s1_valid),
      .s1_tag          (s1_tag),
      .s1_id           (s1_id),
      .s1_x            (s1_x),
      .s1_y            (s1_y),
      .s1_px           (s1_px),
      .s1_py           (s1_py)
   );

   pob_mul #(
      .COORD_BITS (COORD_BITS)
   ) u_mul (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .s1_valid    (s1_valid),
      .s1_tag      (s1_tag),
      .s1_id       (s1_id),
      .s1_x        (s1_x),
      .s1_y        (s1_y),
      .s1_px       (s1_px),
      .s1_py       (s1_py),
      .s2_valid    (s2_valid),
      .s2_tag      (s2_tag),
      .s2_closed   (s2_closed),
      .s2_p1       (s2_p1),
      .s2_p2       (s2_p2),
      .box_min_lon (box_min_lon),
      .box_min_lat (box_min_lat),
      .box_max_lon (box_max_lon),
      .box_max_lat (box_max_lat)
   );

   pob_acc #(
      .COORD_BITS (COORD_BITS),
      .ACC_BITS   (ACC_BITS)
   ) u_acc (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .s2_tag        (s2_tag),
      .s2_closed     (s2_closed),
      .s2_p1         (s2_p1),
      .s2_p2         (s2_p2),
      .box_min_lon   (box_min_lon),
      .box_min_lat   (box_min_lat),
      .box_max_lon   (box_max_lon),
      .box_max_lat   (box_max_lat),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_closed    (rsp_closed),
      .rsp_clockwise (rsp_clockwise),
      .rsp_min_lon   (rsp_min_lon),
      .rsp_min_lat   (rsp_min_lat),
      .rsp_max_lon   (rsp_max_lon),
      .rsp_max_lat   (rsp_max_lat)
   );

endmodule

// ----- design/pob_front.sv -----
// Input stage: captures a vertex beat together with the previous point and first flag.
module pob_front
   import pob_pkg::*;
#(
   parameter int COORD_BITS = POB_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic signed [POB_ID_BITS-1:0]    req_vertex_id,
   input  logic signed [POB_FIELD_BITS-1:0] req_lon,
   input  logic signed [POB_FIELD_BITS-1:0] req_lat,
   input  logic                         req_last_vertex,
   input  pob_adv_type                  adv,
   output logic                         s1_valid,
   output pob_tag_type                  s1_tag,
   output logic [POB_ID_BITS-1:0]       s1_id,
   output logic signed [COORD_BITS-1:0] s1_x,
   output logic signed [COORD_BITS-1:0] s1_y,
   output logic signed [COORD_BITS-1:0] s1_px,
   output logic signed [COORD_BITS-1:0] s1_py
);

   logic                         accept;
   logic                         s1_valid_ff, s1_valid_in;
   logic                         have_first_ff, have_first_in;
   pob_tag_type                  tag_ff;
   logic [POB_ID_BITS-1:0]       id_ff;
   logic signed [COORD_BITS-1:0] x_in, y_in;
   logic signed [COORD_BITS-1:0] x_ff, y_ff, px_ff, py_ff;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_y_ff;

   assign accept = req_valid && adv.s1_take;
   assign x_in   = $signed(req_lon[COORD_BITS-1:0]);
   assign y_in   = $signed(req_lat[COORD_BITS-1:0]);

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      have_first_in = have_first_ff;
      if (adv.s1_take) begin
         s1_valid_in = req_valid;
      end
      if (accept) begin
         have_first_in = !req_last_vertex;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         have_first_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         have_first_ff <= have_first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tag_ff.first <= !have_first_ff;
         tag_ff.last  <= req_last_vertex;
         id_ff        <= req_vertex_id;
         x_ff         <= x_in;
         y_ff         <= y_in;
         px_ff        <= prev_x_ff;
         py_ff        <= prev_y_ff;
         prev_x_ff    <= x_in;
         prev_y_ff    <= y_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_tag   = tag_ff;
   assign s1_id    = id_ff;
   assign s1_x     = x_ff;
   assign s1_y     = y_ff;
   assign s1_px    = px_ff;
   assign s1_py    = py_ff;

endmodule

// ----- design/pob_mul.sv -----
// Product stage: the two cross products, the running box and the closed test.
module pob_mul
   import pob_pkg::*;
#(
   parameter int COORD_BITS = POB_COORD_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pob_adv_type                    adv,
   input  logic                           s1_valid,
   input  pob_tag_type                    s1_tag,
   input  logic [POB_ID_BITS-1:0]         s1_id,
   input  logic signed [COORD_BITS-1:0]   s1_x,
   input  logic signed [COORD_BITS-1:0]   s1_y,
   input  logic signed [COORD_BITS-1:0]   s1_px,
   input  logic signed [COORD_BITS-1:0]   s1_py,
   output logic                           s2_valid,
   output pob_tag_type                    s2_tag,
   output logic                           s2_closed,
   output logic signed [2*COORD_BITS-1:0] s2_p1,
   output logic signed [2*COORD_BITS-1:0] s2_p2,
   output logic signed [COORD_BITS-1:0]   box_min_lon,
   output logic signed [COORD_BITS-1:0]   box_min_lat,
   output logic signed [COORD_BITS-1:0]   box_max_lon,
   output logic signed [COORD_BITS-1:0]   box_max_lat
);

   localparam int PROD_BITS = 2 * COORD_BITS;

   logic                         s2_valid_ff, s2_valid_in;
   pob_tag_type                  tag_ff;
   logic                         closed_ff, closed_in;
   logic signed [PROD_BITS-1:0]  p1_ff, p1_in, p2_ff, p2_in;
   logic [POB_ID_BITS-1:0]       first_id_ff;
   logic signed [COORD_BITS-1:0] min_lon_ff, min_lon_in, max_lon_ff, max_lon_in;
   logic signed [COORD_BITS-1:0] min_lat_ff, min_lat_in, max_lat_ff, max_lat_in;

   // products are exact at twice the coordinate width
   assign p1_in = s1_px * s1_y;
   assign p2_in = s1_x * s1_py;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (adv.s2_take) begin
         s2_valid_in = s1_valid;
      end
   end

   always_comb begin
      closed_in  = s1_tag.first || (first_id_ff == s1_id);
      min_lon_in = min_lon_ff;
      max_lon_in = max_lon_ff;
      min_lat_in = min_lat_ff;
      max_lat_in = max_lat_ff;
      if (s1_tag.first) begin
         min_lon_in = s1_x;
         max_lon_in = s1_x;
         min_lat_in = s1_y;
         max_lat_in = s1_y;
      end else begin
         if (s1_x < min_lon_ff) min_lon_in = s1_x;
         if (s1_x > max_lon_ff) max_lon_in = s1_x;
         if (s1_y < min_lat_ff) min_lat_in = s1_y;
         if (s1_y > max_lat_ff) max_lat_in = s1_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   // box and first id act as this stage's payload: they always reflect the item in it
   always_ff @(posedge clock) begin
      if (adv.s1_go) begin
         tag_ff     <= s1_tag;
         closed_ff  <= closed_in;
         p1_ff      <= p1_in;
         p2_ff      <= p2_in;
         min_lon_ff <= min_lon_in;
         max_lon_ff <= max_lon_in;
         min_lat_ff <= min_lat_in;
         max_lat_ff <= max_lat_in;
         if (s1_tag.first) begin
            first_id_ff <= s1_id;
         end
      end
   end

   assign s2_valid    = s2_valid_ff;
   assign s2_tag      = tag_ff;
   assign s2_closed   = closed_ff;
   assign s2_p1       = p1_ff;
   assign s2_p2       = p2_ff;
   assign box_min_lon = min_lon_ff;
   assign box_min_lat = min_lat_ff;
   assign box_max_lon = max_lon_ff;
   assign box_max_lat = max_lat_ff;

endmodule

// ----- design/pob_acc.sv -----
// Accumulate stage: shoelace sum and the result register.
`include "polygon_orientation_and_bbox_defines.svh"

module pob_acc
   import pob_pkg::*;
#(
   parameter int COORD_BITS = POB_COORD_BITS,
   parameter int ACC_BITS   = POB_ACC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pob_adv_type                       adv,
   input  pob_tag_type                       s2_tag,
   input  logic                              s2_closed,
   input  logic signed [2*COORD_BITS-1:0]    s2_p1,
   input  logic signed [2*COORD_BITS-1:0]    s2_p2,
   input  logic signed [COORD_BITS-1:0]      box_min_lon,
   input  logic signed [COORD_BITS-1:0]      box_min_lat,
   input  logic signed [COORD_BITS-1:0]      box_max_lon,
   input  logic signed [COORD_BITS-1:0]      box_max_lat,
   output logic                              out_free,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_closed,
   output logic                              rsp_clockwise,
   output logic signed [POB_FIELD_BITS-1:0]  rsp_min_lon,
   output logic signed [POB_FIELD_BITS-1:0]  rsp_min_lat,
   output logic signed [POB_FIELD_BITS-1:0]  rsp_max_lon,
   output logic signed [POB_FIELD_BITS-1:0]  rsp_max_lat
);

   localparam int PROD_BITS = 2 * COORD_BITS;
   localparam int WIDE_BITS = (PROD_BITS > ACC_BITS) ? PROD_BITS : ACC_BITS;

   logic signed [WIDE_BITS-1:0]      p1_wide, p2_wide;
   logic [ACC_BITS-1:0]              acc_ff, acc_in;
   logic                             load;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             closed_ff, clockwise_ff;
   logic signed [POB_FIELD_BITS-1:0] min_lon_ff, min_lat_ff, max_lon_ff, max_lat_ff;

   // sign-extend, then keep the low accumulator bits: the sum wraps
   assign p1_wide = WIDE_BITS'(s2_p1);
   assign p2_wide = WIDE_BITS'(s2_p2);
   assign load    = adv.s2_go && s2_tag.last;

   always_comb begin
      acc_in = acc_ff;
      if (adv.s2_go) begin
         if (s2_tag.first) begin
            acc_in = '0;
         end else begin
            acc_in = acc_ff + p1_wide[ACC_BITS-1:0] - p2_wide[ACC_BITS-1:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         closed_ff    <= s2_closed;
         clockwise_ff <= s2_closed && acc_in[ACC_BITS-1];
         min_lon_ff   <= POB_FIELD_BITS'(box_min_lon);
         min_lat_ff   <= POB_FIELD_BITS'(box_min_lat);
         max_lon_ff   <= POB_FIELD_BITS'(box_max_lon);
         max_lat_ff   <= POB_FIELD_BITS'(box_max_lat);
      end
   end

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_closed    = closed_ff;
   assign rsp_clockwise = clockwise_ff;
   assign rsp_min_lon   = min_lon_ff;
   assign rsp_min_lat   = min_lat_ff;
   assign rsp_max_lon   = max_lon_ff;
   assign rsp_max_lat   = max_lat_ff;

   `POB_ASSERT_ALWAYS(a_no_overwrite, clock, reset, !load || out_free)
   `POB_ASSERT_NEXT(a_last_loads, clock, reset, load, rsp_valid_ff)
   `POB_ASSERT_NEXT(a_first_clears, clock, reset, adv.s2_go && s2_tag.first, acc_ff == '0)
   `POB_ASSERT_ALWAYS(a_cw_needs_closed, clock, reset, !rsp_valid_ff || closed_ff || !clockwise_ff)

endmodule
